// ----- hdl/mbk_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and the character-to-Morse table of the beacon keyer.
// Depends on nothing; every other file of the keyer but mbk_ram uses it.
package mbk_pkg;

  localparam int unsigned MSG_DEPTH = 64;
  localparam int unsigned MSG_AW    = $clog2(MSG_DEPTH);
  localparam int unsigned TIME_W    = 16;
  localparam int unsigned LEN_W     = 7;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned SYM_W     = 3;

  localparam logic [7:0] SPACE_CODE = 8'h20;

  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DOT_MS        = 3'd0,
    CFG_DASH_MS       = 3'd1,
    CFG_SYMBOL_GAP_MS = 3'd2,
    CFG_CHAR_GAP_MS   = 3'd3,
    CFG_WORD_GAP_MS   = 3'd4,
    CFG_MSG_LENGTH    = 3'd5
  } cfg_idx_e;

  // Symbols are left-justified in bits: the first symbol sits in bit 6, a one is a dash.
  typedef struct packed {
    logic             is_space;
    logic [SYM_W-1:0] len;
    logic [6:0]       bits;
  } morse_pat_t;

  typedef struct packed {
    logic              key_on;
    logic              band_change;
    logic [MSG_AW-1:0] position;
  } result_t;

  function automatic morse_pat_t morse_lookup(input logic [7:0] code);
    morse_pat_t p;
    p = '{is_space: 1'b1, len: 3'd1, bits: 7'b0000000};
    case (code)
      "A": p = '{1'b0, 3'd2, 7'b0100000};
      "B": p = '{1'b0, 3'd4, 7'b1000000};
      "C": p = '{1'b0, 3'd4, 7'b1010000};
      "D": p = '{1'b0, 3'd3, 7'b1000000};
      "E": p = '{1'b0, 3'd1, 7'b0000000};
      "F": p = '{1'b0, 3'd4, 7'b0010000};
      "G": p = '{1'b0, 3'd3, 7'b1100000};
      "H": p = '{1'b0, 3'd4, 7'b0000000};
      "I": p = '{1'b0, 3'd2, 7'b0000000};
      "J": p = '{1'b0, 3'd4, 7'b0111000};
      "K": p = '{1'b0, 3'd3, 7'b1010000};
      "L": p = '{1'b0, 3'd4, 7'b0100000};
      "M": p = '{1'b0, 3'd2, 7'b1100000};
      "N": p = '{1'b0, 3'd2, 7'b1000000};
      "O": p = '{1'b0, 3'd3, 7'b1110000};
      "P": p = '{1'b0, 3'd4, 7'b0110000};
      "Q": p = '{1'b0, 3'd4, 7'b1101000};
      "R": p = '{1'b0, 3'd3, 7'b0100000};
      "S": p = '{1'b0, 3'd3, 7'b0000000};
      "T": p = '{1'b0, 3'd1, 7'b1000000};
      "U": p = '{1'b0, 3'd3, 7'b0010000};
      "V": p = '{1'b0, 3'd4, 7'b0001000};
      "W": p = '{1'b0, 3'd3, 7'b0110000};
      "X": p = '{1'b0, 3'd4, 7'b1001000};
      "Y": p = '{1'b0, 3'd4, 7'b1011000};
      "Z": p = '{1'b0, 3'd4, 7'b1100000};
      "1": p = '{1'b0, 3'd5, 7'b0111100};
      "2": p = '{1'b0, 3'd5, 7'b0011100};
      "3": p = '{1'b0, 3'd5, 7'b0001100};
      "4": p = '{1'b0, 3'd5, 7'b0000100};
      "5": p = '{1'b0, 3'd5, 7'b0000000};
      "6": p = '{1'b0, 3'd5, 7'b1000000};
      "7": p = '{1'b0, 3'd5, 7'b1100000};
      "8": p = '{1'b0, 3'd5, 7'b1110000};
      "9": p = '{1'b0, 3'd5, 7'b1111000};
      "0": p = '{1'b0, 3'd5, 7'b1111100};
      "?": p = '{1'b0, 3'd6, 7'b0011000};
      ".": p = '{1'b0, 3'd6, 7'b0101010};
      ",": p = '{1'b0, 3'd6, 7'b1100110};
      "!": p = '{1'b0, 3'd6, 7'b1010110};
      "@": p = '{1'b0, 3'd6, 7'b0110100};
      ":": p = '{1'b0, 3'd6, 7'b1110000};
      "-": p = '{1'b0, 3'd6, 7'b1000010};
      "/": p = '{1'b0, 3'd5, 7'b1001000};
      "(": p = '{1'b0, 3'd5, 7'b1011000};
      ")": p = '{1'b0, 3'd6, 7'b1011010};
      "_": p = '{1'b0, 3'd5, 7'b0100000};
      "$": p = '{1'b0, 3'd7, 7'b0001001};
      ">": p = '{1'b0, 3'd6, 7'b0001010};
      "<": p = '{1'b0, 3'd5, 7'b0101000};
      "~": p = '{1'b0, 3'd5, 7'b0001000};
      default: p = '{1'b1, 3'd1, 7'b0000000};
    endcase
    return p;
  endfunction

endpackage

// ----- hdl/mbk_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the beacon keyer: requests in, results out.
// Depends on mbk_pkg for widths.
interface mbk_req_if;
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [5:0]                char_addr;
  logic [7:0]                char_code;

  modport source (output valid, req_type, char_addr, char_code, input ready);
  modport sink   (input valid, req_type, char_addr, char_code, output ready);
endinterface

interface mbk_res_if;
  logic                      valid;
  logic                      ready;
  logic                      key_on;
  logic                      band_change;
  logic [mbk_pkg::MSG_AW-1:0] position;

  modport source (output valid, key_on, band_change, position, input ready);
  modport sink   (input valid, key_on, band_change, position, output ready);
endinterface

// ----- hdl/morse_beacon_keyer.sv -----
`timescale 1ns / 1ps
// Top level of the repeating Morse beacon keyer: timing registers, keying sequencer
// and result skid buffer. Depends on mbk_pkg, mbk_if and mbk_ram.
//
//   Channel | Direction | Handshake     | Contents
//   req     | in        | valid / ready | req_type, char_addr, char_code
//   res     | out       | valid / ready | key_on, band_change, position
//   cfg     | in        | cfg_we_i      | cfg_idx_i, cfg_data_i
//
// One request can be accepted in every cycle while the skid register is empty.
// The message store RAM is read each cycle at the next character position, so the
// current character is ready when a tick arrives; a write to that same entry is forwarded.
// After reset the store reads as spaces through per-entry valid bits; no clearing pass.
// A stalled result moves into a skid register; req.ready drops only while it is full.
module morse_beacon_keyer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mbk_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mbk_pkg::TIME_W-1:0]    cfg_data_i,
  mbk_req_if.sink                       req,
  mbk_res_if.source                     res
);
  import mbk_pkg::*;

  typedef enum logic {PH_FETCH, PH_KEY} phase_e;

  logic [TIME_W-1:0] dot_ms_q, dash_ms_q, sym_gap_q, char_gap_q, word_gap_q;
  logic [LEN_W-1:0]  msg_len_q;

  logic [MSG_AW-1:0] char_pos_q, char_pos_d;
  logic [SYM_W-1:0]  sym_pos_q, sym_pos_d;
  phase_e            phase_q, phase_d;
  logic [TIME_W-1:0] wait_q, wait_d, wait_dec;
  logic              key_q, key_d;
  logic              band;

  logic [MSG_DEPTH-1:0] valid_q;
  logic                 fwd_q, fwd_d;
  logic [7:0]           fwd_data_q;
  logic [7:0]           ram_rdata;
  logic [7:0]           cur_code;
  morse_pat_t           pat;

  logic                 req_acc, is_write;
  logic [LEN_W-1:0]     eff_len;
  logic [LEN_W-1:0]     pos_inc;
  logic [SYM_W:0]       sym_next;

  result_t              new_res, out_q, skid_q;
  logic                 out_valid_q, skid_valid_q;

  assign req.ready = !skid_valid_q;
  assign req_acc   = req.valid && req.ready;
  assign is_write  = (req.req_type == REQ_WRITE);

  assign fwd_d = req_acc && is_write && (req.char_addr == char_pos_d);

  mbk_ram #(
    .WIDTH(8),
    .DEPTH(MSG_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (req_acc && is_write),
    .waddr_i(MSG_AW'(req.char_addr)),
    .wdata_i(req.char_code),
    .raddr_i(char_pos_d),
    .rdata_o(ram_rdata)
  );

  assign cur_code = fwd_q ? fwd_data_q : (valid_q[char_pos_q] ? ram_rdata : SPACE_CODE);
  assign pat      = morse_lookup(cur_code);

  always_comb begin
    eff_len = msg_len_q;
    if (msg_len_q == '0) begin
      eff_len = LEN_W'(1);
    end else if (msg_len_q > LEN_W'(MSG_DEPTH)) begin
      eff_len = LEN_W'(MSG_DEPTH);
    end
  end

  assign pos_inc  = LEN_W'(char_pos_q) + LEN_W'(1);
  assign sym_next = {1'b0, sym_pos_q} + (SYM_W+1)'(1);
  assign wait_dec = (wait_q != '0) ? wait_q - TIME_W'(1) : wait_q;

  always_comb begin
    char_pos_d = char_pos_q;
    sym_pos_d  = sym_pos_q;
    phase_d    = phase_q;
    wait_d     = wait_q;
    key_d      = key_q;
    band       = 1'b0;
    if (req_acc && !is_write) begin
      wait_d = wait_dec;
      if (wait_dec == '0) begin
        if (phase_q == PH_KEY) begin
          if (sym_next >= {1'b0, pat.len}) begin
            sym_pos_d = '0;
            if (pos_inc >= eff_len) begin
              char_pos_d = '0;
              wait_d     = word_gap_q;
              band       = 1'b1;
            end else begin
              char_pos_d = MSG_AW'(pos_inc);
              wait_d     = char_gap_q;
            end
          end else begin
            sym_pos_d = sym_next[SYM_W-1:0];
            wait_d    = sym_gap_q;
          end
          phase_d = PH_FETCH;
          key_d   = 1'b0;
        end else begin
          key_d = 1'b0;
          if (sym_pos_q < pat.len) begin
            if (pat.is_space) begin
              wait_d = word_gap_q;
            end else if (pat.bits[3'd6 - sym_pos_q]) begin
              wait_d = dash_ms_q;
              key_d  = 1'b1;
            end else begin
              wait_d = dot_ms_q;
              key_d  = 1'b1;
            end
          end
          phase_d = PH_KEY;
        end
      end
    end
  end

  assign new_res = '{key_on: key_d, band_change: band, position: char_pos_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_ms_q   <= TIME_W'(60);
      dash_ms_q  <= TIME_W'(180);
      sym_gap_q  <= TIME_W'(60);
      char_gap_q <= TIME_W'(180);
      word_gap_q <= TIME_W'(420);
      msg_len_q  <= LEN_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DOT_MS:        dot_ms_q   <= cfg_data_i;
        CFG_DASH_MS:       dash_ms_q  <= cfg_data_i;
        CFG_SYMBOL_GAP_MS: sym_gap_q  <= cfg_data_i;
        CFG_CHAR_GAP_MS:   char_gap_q <= cfg_data_i;
        CFG_WORD_GAP_MS:   word_gap_q <= cfg_data_i;
        CFG_MSG_LENGTH:    msg_len_q  <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_pos_q <= '0;
      sym_pos_q  <= '0;
      phase_q    <= PH_FETCH;
      wait_q     <= '0;
      key_q      <= 1'b0;
      valid_q    <= '0;
      fwd_q      <= 1'b0;
    end else begin
      char_pos_q <= char_pos_d;
      sym_pos_q  <= sym_pos_d;
      phase_q    <= phase_d;
      wait_q     <= wait_d;
      key_q      <= key_d;
      fwd_q      <= fwd_d;
      if (req_acc && is_write) begin
        valid_q[MSG_AW'(req.char_addr)] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= req.char_code;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (res.ready || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= req_acc;
      end
    end else if (req_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.ready || !out_valid_q) begin
      out_q <= skid_valid_q ? skid_q : new_res;
    end else if (req_acc) begin
      skid_q <= new_res;
    end
  end

  assign res.valid       = out_valid_q;
  assign res.key_on      = out_q.key_on;
  assign res.band_change = out_q.band_change;
  assign res.position    = out_q.position;

endmodule

// ----- hdl/mbk_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; sized by its parameters.
module mbk_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/mbk_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks of the beacon keyer and the bind that attaches them to the top level.
// Depends on mbk_pkg and morse_beacon_keyer.
module mbk_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       req_valid,
  input logic                       req_ready,
  input logic                       res_valid,
  input logic                       res_ready,
  input logic                       res_key_on,
  input logic                       res_band_change,
  input logic [mbk_pkg::MSG_AW-1:0] res_position
);
  import mbk_pkg::*;

  // A stalled result must stay offered.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid)
    else $error("result withdrawn while stalled");

  // A wrap always lands on the first character.
  a_wrap_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_band_change |-> res_position == '0)
    else $error("band change away from position zero");

  // The wrap step ends the key phase of a symbol, so the key is off.
  a_wrap_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_band_change |-> !res_key_on)
    else $error("band change with key on");

  // Requests are held off only while a result waits at the output.
  a_ready_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_ready |-> res_valid && $past(res_valid && !res_ready))
    else $error("request stall without a stalled result");

  // The skid stage fills only from an accepted request behind a stalled result.
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(req_ready) |-> $past(req_valid))
    else $error("request stall without an accepted request");

endmodule

bind morse_beacon_keyer mbk_checker u_mbk_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .res_key_on     (res.key_on),
  .res_band_change(res.band_change),
  .res_position   (res.position)
);

// ----- tb/morse_beacon_keyer_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the Morse beacon keyer: a cycle-free predictor checks every result.
// Depends on mbk_pkg, mbk_if and morse_beacon_keyer.
module morse_beacon_keyer_tb;
  import mbk_pkg::*;

  localparam byte SYM_DOT  = ".";
  localparam byte SYM_DASH = "-";
  localparam byte SYM_GAP  = " ";
  localparam int  LONG_HOLD_CYCLES = 80;

  class beacon_tracker;
    string char_list;
    string pats[$];
    logic [7:0]        store [MSG_DEPTH];
    logic [MSG_AW-1:0] char_pos;
    int                sym_pos;
    bit                keying;
    logic [TIME_W-1:0] wait_left;
    bit                key_flag;
    logic [TIME_W-1:0] dot_t, dash_t, sym_gap_t, char_gap_t, word_gap_t;
    logic [LEN_W-1:0]  msg_len;
    result_t           expected_keying[$];
    int                mismatches;

    function new();
      char_list = " ABCDEFGHIJKLMNOPQRSTUVWXYZ1234567890?.,!@:-/()_$><~";
      pats = '{" ", ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
               ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...",
               "-", "..-", "...-", ".--", "-..-", "-.--", "--..",
               ".----", "..---", "...--", "....-", ".....", "-....", "--...", "---..",
               "----.", "-----",
               "..--..", ".-.-.-", "--..--", "-.-.--", ".--.-.", "---...", "-....-",
               "-..-.", "-.--.", "-.--.-", ".-...", "...-..-", "...-.-", ".-.-.",
               "...-."};
      foreach (store[i]) store[i] = SPACE_CODE;
      char_pos   = '0;
      sym_pos    = 0;
      keying     = 1'b0;
      wait_left  = '0;
      key_flag   = 1'b0;
      dot_t      = 16'd60;
      dash_t     = 16'd180;
      sym_gap_t  = 16'd60;
      char_gap_t = 16'd180;
      word_gap_t = 16'd420;
      msg_len    = 7'd1;
      mismatches = 0;
    endfunction

    function void report(string what);
      if (mismatches < 200) $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
    endfunction

    function int effective_length(logic [LEN_W-1:0] n);
      if (n == 0) return 1;
      if (n > MSG_DEPTH) return MSG_DEPTH;
      return int'(n);
    endfunction

    function string pattern_for(logic [7:0] code);
      int i;
      for (i = 0; i < char_list.len(); i++)
        if (char_list[i] == code) return pats[i];
      return " ";
    endfunction

    function void set_register(cfg_idx_e idx, logic [TIME_W-1:0] val);
      case (idx)
        CFG_DOT_MS:        dot_t = val;
        CFG_DASH_MS:       dash_t = val;
        CFG_SYMBOL_GAP_MS: sym_gap_t = val;
        CFG_CHAR_GAP_MS:   char_gap_t = val;
        CFG_WORD_GAP_MS:   word_gap_t = val;
        CFG_MSG_LENGTH:    msg_len = val[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_request(logic rtype, logic [5:0] addr, logic [7:0] code);
      string   pat;
      int      plen;
      byte     sym;
      bit      band;
      result_t r;
      band = 1'b0;
      if (rtype == REQ_WRITE) begin
        store[addr] = code;
      end else begin
        if (wait_left != 0) wait_left--;
        if (wait_left == 0) begin
          pat  = pattern_for(store[char_pos]);
          plen = pat.len();
          if (keying) begin
            if (sym_pos + 1 >= plen) begin
              sym_pos   = 0;
              wait_left = char_gap_t;
              if (int'(char_pos) + 1 >= effective_length(msg_len)) begin
                char_pos  = '0;
                wait_left = word_gap_t;
                band      = 1'b1;
              end else begin
                char_pos = char_pos + 1'b1;
              end
            end else begin
              sym_pos   = sym_pos + 1;
              wait_left = sym_gap_t;
            end
            keying   = 1'b0;
            key_flag = 1'b0;
          end else begin
            sym = (sym_pos < plen) ? pat[sym_pos] : 8'd0;
            if (sym == SYM_DOT) begin
              wait_left = dot_t;
              key_flag  = 1'b1;
            end else if (sym == SYM_DASH) begin
              wait_left = dash_t;
              key_flag  = 1'b1;
            end else if (sym == SYM_GAP) begin
              wait_left = word_gap_t;
              key_flag  = 1'b0;
            end else begin
              key_flag = 1'b0;
            end
            keying = 1'b1;
          end
        end
      end
      r.key_on      = key_flag;
      r.band_change = band;
      r.position    = char_pos;
      expected_keying.push_back(r);
    endfunction

    function void check_result(logic key_on, logic band_change, logic [MSG_AW-1:0] position);
      result_t e;
      if (expected_keying.size() == 0) begin
        report("result with no request outstanding");
        return;
      end
      e = expected_keying.pop_front();
      if (key_on !== e.key_on)
        report($sformatf("key_on %b, expected %b", key_on, e.key_on));
      if (band_change !== e.band_change)
        report($sformatf("band_change %b, expected %b", band_change, e.band_change));
      if (position !== e.position)
        report($sformatf("position %0d, expected %0d", position, e.position));
    endfunction

    function int pending();
      return expected_keying.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [TIME_W-1:0] cfg_data_i;

  mbk_req_if req_ch ();
  mbk_res_if res_ch ();

  beacon_tracker sb;
  int send_idle_pct;
  int res_idle_pct;
  bit hold_result;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  morse_beacon_keyer u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req        (req_ch),
    .res        (res_ch)
  );

  always @(posedge clk_i) begin
    if (rst_ni && req_ch.valid && req_ch.ready)
      sb.note_request(req_ch.req_type, req_ch.char_addr, req_ch.char_code);
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready)
      sb.check_result(res_ch.key_on, res_ch.band_change, res_ch.position);
  end

  initial begin
    int stall_left;
    stall_left = 0;
    res_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
      end else if (hold_result) begin
        hold_result = 1'b0;
        stall_left  = LONG_HOLD_CYCLES;
      end else if (res_idle_pct > 0 && $urandom_range(1, 100) <= res_idle_pct) begin
        stall_left = $urandom_range(1, 7);
      end
      res_ch.ready <= (stall_left == 0);
    end
  end

  initial begin
    #400000;
    $display("FAIL");
    $finish;
  end

  task automatic send_item(logic rtype, logic [5:0] addr, logic [7:0] code);
    if (send_idle_pct > 0 && $urandom_range(1, 100) <= send_idle_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= rtype;
    req_ch.char_addr <= addr;
    req_ch.char_code <= code;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  task automatic send_tick();
    send_item(REQ_TICK, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
  endtask

  task automatic wait_all_results();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [TIME_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.set_register(idx, val);
  endtask

  task automatic program_regs(logic [TIME_W-1:0] dot, logic [TIME_W-1:0] dash,
                              logic [TIME_W-1:0] sgap, logic [TIME_W-1:0] cgap,
                              logic [TIME_W-1:0] wgap, logic [LEN_W-1:0] len);
    write_reg(CFG_DOT_MS, dot);
    write_reg(CFG_DASH_MS, dash);
    write_reg(CFG_SYMBOL_GAP_MS, sgap);
    write_reg(CFG_CHAR_GAP_MS, cgap);
    write_reg(CFG_WORD_GAP_MS, wgap);
    write_reg(CFG_MSG_LENGTH, TIME_W'(len));
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [7:0] pick_char();
    if ($urandom_range(0, 3) != 0)
      return sb.char_list[$urandom_range(0, sb.char_list.len() - 1)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [TIME_W-1:0] pick_time();
    case ($urandom_range(0, 9))
      0:       return '0;
      8:       return TIME_W'($urandom_range(4, 8));
      default: return TIME_W'($urandom_range(1, 3));
    endcase
  endfunction

  function automatic int pick_idle();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 10;
      default: return 35;
    endcase
  endfunction

  task automatic keying_phase(bit pressure, bit long_msg, bit calm);
    logic [LEN_W-1:0] len;
    int eff;
    int k;
    case ($urandom_range(0, 9))
      0:       len = '0;
      1:       len = 7'd64;
      2:       len = 7'($urandom_range(65, 127));
      default: len = 7'($urandom_range(1, 5));
    endcase
    if (long_msg) begin
      len = 7'd64;
      program_regs(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, len);
    end else begin
      program_regs(pick_time(), pick_time(), pick_time(), pick_time(), pick_time(), len);
    end
    eff = sb.effective_length(len);
    send_idle_pct = calm ? 0 : pick_idle();
    res_idle_pct  = calm ? 0 : pick_idle();
    if (pressure) begin
      send_idle_pct = 0;
      hold_result   = 1'b1;
    end
    for (k = 0; k < eff; k++) send_item(REQ_WRITE, 6'(k), pick_char());
    repeat (130) begin
      if ($urandom_range(1, 100) <= 8) begin
        if ($urandom_range(0, 9) < 7)
          send_item(REQ_WRITE, 6'($urandom_range(0, eff - 1)), pick_char());
        else
          send_item(REQ_WRITE, 6'($urandom_range(0, 63)), pick_char());
      end else begin
        send_tick();
      end
    end
    wait_all_results();
  endtask

  initial begin
    int phase;
    sb = new();
    send_idle_pct = 0;
    res_idle_pct  = 0;
    hold_result   = 1'b0;
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= CFG_DOT_MS;
    cfg_data_i       <= '0;
    req_ch.valid     <= 1'b0;
    req_ch.req_type  <= REQ_TICK;
    req_ch.char_addr <= '0;
    req_ch.char_code <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset register values: unknown and lowercase codes, then a dot keyed on.
    send_item(REQ_WRITE, 6'd63, 8'hFF);
    send_item(REQ_WRITE, 6'd0, 8'h00);
    send_item(REQ_WRITE, 6'd0, "a");
    send_item(REQ_WRITE, 6'd1, "$");
    send_item(REQ_WRITE, 6'd0, "E");
    send_item(REQ_TICK, 6'h2A, 8'h55);
    send_item(REQ_TICK, 6'h15, 8'hAA);
    wait_all_results();

    // Zero timing and zero length: every tick runs a step once the old wait runs out.
    // Rewriting a long character with a short one leaves the symbol index past its end.
    program_regs('0, '0, '0, '0, '0, '0);
    repeat (64) send_tick();
    send_item(REQ_WRITE, 6'd0, "0");
    repeat (5) send_tick();
    send_item(REQ_WRITE, 6'd0, "E");
    repeat (2) send_tick();
    send_item(REQ_WRITE, 6'd0, "0");
    repeat (6) send_tick();
    send_item(REQ_WRITE, 6'd0, "E");
    repeat (2) send_tick();
    wait_all_results();

    for (phase = 0; phase < 12; phase++)
      keying_phase(phase == 2, phase == 5, phase >= 10);

    // Largest register values; the length above the store depth acts as the full store.
    program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7'h7F);
    send_item(REQ_WRITE, 6'd0, "T");
    repeat (40) send_tick();
    wait_all_results();

    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
